>>> sv/trcd_pkg.sv
`default_nettype none

package trcd_pkg;

    localparam int REPORT_LENGTH_DEFAULT = 10;
    localparam int QUEUE_DEPTH_DEFAULT   = 2;

    localparam int RES_W   = 13;
    localparam int COORD_W = 12;
    localparam int PROD_W  = COORD_W + RES_W;
    localparam int CIDX_W  = 2;

    localparam logic [7:0]       MAGIC_VALUE    = 8'hAB;
    localparam logic [7:0]       POINT_MASK     = 8'h7F;
    localparam logic [7:0]       STATUS_MASK    = 8'h0F;
    localparam logic [7:0]       STATUS_TOUCH   = 8'h06;
    localparam logic [RES_W-1:0] RAW_FULL_SCALE = 13'd4096;
    localparam logic [RES_W-1:0] RES_RESET      = 13'd480;

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_BUS_FAIL = 1'b1;

    localparam logic [CIDX_W-1:0] REG_ROTATION = 2'd0;
    localparam logic [CIDX_W-1:0] REG_H_RES    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_V_RES    = 2'd2;

    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } rotation_t;

    typedef enum logic [2:0] {
        OUT_OK,
        OUT_BAD_MAGIC,
        OUT_NO_POINTS,
        OUT_BAD_STATUS,
        OUT_BUS_ERROR
    } outcome_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        outcome_t           outcome;
        logic               finger_present;
    } out_word_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
    } job_t;

    typedef struct packed {
        rotation_t        rotation;
        logic [RES_W-1:0] h_res;
        logic [RES_W-1:0] v_res;
    } cfg_t;

    function automatic logic [RES_W-1:0] sat_res(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] s;
        s = r;
        if (r == '0)
        begin
            s = RES_W'(1);
        end
        else if (r > RAW_FULL_SCALE)
        begin
            s = RAW_FULL_SCALE;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/trcd_fifo.sv
`default_nettype none

module trcd_fifo #(
    parameter type word_t = logic,
    parameter int  DEPTH  = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire word_t word_in,
    output logic       full,
    input  wire logic  pop,
    output word_t      word_out,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign word_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= word_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/trcd_front.sv
`default_nettype none

module trcd_front #(
    parameter int REPORT_LENGTH = trcd_pkg::REPORT_LENGTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire trcd_pkg::in_word_t data,
    output logic                    full,
    output logic                    q_push,
    output trcd_pkg::job_t          q_word,
    input  wire logic               q_full
);

    import trcd_pkg::*;

    localparam int POS_W  = $clog2(REPORT_LENGTH);
    localparam int KEEP_N = 7;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       byte_reg  [KEEP_N];
    logic [7:0]       byte_next [KEEP_N];
    logic [7:0]       view      [KEEP_N];
    logic             accept;
    logic             last;
    logic             is_byte;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign is_byte = (data.command == CMD_BYTE);
    assign last    = (pos_reg == POS_W'(REPORT_LENGTH - 1));
    assign q_push  = accept && (!is_byte || last);

    // merge the arriving byte so the final byte is seen in the same cycle
    always_comb
    begin
        for (int k = 0; k < KEEP_N; k++)
        begin
            view[k]      = (pos_reg == POS_W'(k)) ? data.data_byte : byte_reg[k];
            byte_next[k] = (accept && is_byte && pos_reg == POS_W'(k))
                           ? data.data_byte : byte_reg[k];
        end
    end

    always_comb
    begin
        q_word.raw_x = {view[1], view[3][7:4]};
        q_word.raw_y = {view[2], view[3][3:0]};
        if (!is_byte)
        begin
            q_word.outcome = OUT_BUS_ERROR;
        end
        else if (view[6] != MAGIC_VALUE)
        begin
            q_word.outcome = OUT_BAD_MAGIC;
        end
        else if ((view[5] & POINT_MASK) == '0)
        begin
            q_word.outcome = OUT_NO_POINTS;
        end
        else if ((view[0] & STATUS_MASK) != STATUS_TOUCH)
        begin
            q_word.outcome = OUT_BAD_STATUS;
        end
        else
        begin
            q_word.outcome = OUT_OK;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (!is_byte || last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < KEEP_N; k++)
        begin
            byte_reg[k] <= byte_next[k];
        end
    end

endmodule

`default_nettype wire

>>> sv/trcd_back.sv
`default_nettype none

module trcd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire trcd_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire trcd_pkg::job_t q_word,
    output logic                q_pop,
    output logic                out_push,
    output trcd_pkg::out_word_t out_word,
    input  wire logic           out_full
);

    import trcd_pkg::*;

    logic               a_valid_reg, a_valid_next;
    outcome_t           a_outcome_reg;
    logic [COORD_W-1:0] a_x_reg, a_y_reg;
    logic [PROD_W-1:0]  a_px_reg, a_py_reg;
    logic               a_xge_reg, a_yge_reg;

    logic               b_valid_reg, b_valid_next;
    outcome_t           b_outcome_reg;
    logic [COORD_W-1:0] b_xs_reg, b_ys_reg, b_ym_reg, b_xr_reg;

    logic               finger_reg, finger_next;

    logic               b_free, a_adv, a_free;
    logic [COORD_W-1:0] hm1, vm1, xs, ys, tx, ty, cx, cy;

    assign hm1 = COORD_W'(cfg.h_res - RES_W'(1));
    assign vm1 = COORD_W'(cfg.v_res - RES_W'(1));

    assign out_push = b_valid_reg && !out_full;
    assign b_free   = !b_valid_reg || out_push;
    assign a_adv    = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || a_adv;
    assign q_pop    = !q_empty && a_free;

    assign a_valid_next = q_pop || (a_valid_reg && !a_adv);
    assign b_valid_next = a_adv || (b_valid_reg && !out_push);

    // scale down raw values at or above the resolution
    assign xs = a_xge_reg ? a_px_reg[PROD_W-2:COORD_W] : a_x_reg;
    assign ys = a_yge_reg ? a_py_reg[PROD_W-2:COORD_W] : a_y_reg;

    always_comb
    begin
        case (cfg.rotation)
            ROT_90:
            begin
                tx = b_ys_reg;
                ty = b_xs_reg;
            end
            ROT_180:
            begin
                tx = b_xr_reg;
                ty = b_ys_reg;
            end
            ROT_270:
            begin
                tx = b_ym_reg;
                ty = b_xr_reg;
            end
            default:
            begin
                tx = b_xs_reg;
                ty = b_ym_reg;
            end
        endcase
        cx = ({1'b0, tx} >= cfg.h_res) ? hm1 : tx;
        cy = ({1'b0, ty} >= cfg.v_res) ? vm1 : ty;
    end

    always_comb
    begin
        case (b_outcome_reg)
            OUT_OK:        finger_next = 1'b1;
            OUT_NO_POINTS: finger_next = 1'b0;
            OUT_BUS_ERROR: finger_next = 1'b0;
            default:       finger_next = finger_reg;
        endcase
        out_word.outcome        = b_outcome_reg;
        out_word.finger_present = finger_next;
        out_word.x_coord        = (b_outcome_reg == OUT_OK) ? cx : '0;
        out_word.y_coord        = (b_outcome_reg == OUT_OK) ? cy : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            finger_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            if (out_push)
            begin
                finger_reg <= finger_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_outcome_reg <= q_word.outcome;
            a_x_reg       <= q_word.raw_x;
            a_y_reg       <= q_word.raw_y;
            a_px_reg      <= PROD_W'(q_word.raw_x) * PROD_W'(cfg.h_res);
            a_py_reg      <= PROD_W'(q_word.raw_y) * PROD_W'(cfg.v_res);
            a_xge_reg     <= ({1'b0, q_word.raw_x} >= cfg.h_res);
            a_yge_reg     <= ({1'b0, q_word.raw_y} >= cfg.v_res);
        end
        if (a_adv)
        begin
            b_outcome_reg <= a_outcome_reg;
            b_xs_reg      <= xs;
            b_ys_reg      <= ys;
            b_ym_reg      <= vm1 - ys;
            b_xr_reg      <= hm1 - xs;
        end
    end

endmodule

`default_nettype wire

>>> sv/touch_report_coordinate_decoder.sv
`default_nettype none

// channel   handshake               payload
// input     push / full             data   (command, data_byte)
// result    empty / pop             result (x_coord, y_coord, outcome, finger_present)
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte word is taken per cycle while the decode queue has room.
// A result for the word ending a report or a bus failure passes in order through the decode
// queue, the multiply stage, the scale/mirror stage and the result queue.
// Results leave at one per cycle while pop keeps up; a full result queue stalls the back part
// and a full decode queue stalls the input, so either side may stall alone.
// Reset clears the byte position, the finger flag and the queues; config resets to
// rotation 0 and 480 x 480.

module touch_report_coordinate_decoder #(
    parameter int REPORT_LENGTH = trcd_pkg::REPORT_LENGTH_DEFAULT,
    parameter int QUEUE_DEPTH   = trcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire trcd_pkg::in_word_t                  data,
    output logic                                     full,
    output logic                                     empty,
    input  wire logic                                pop,
    output trcd_pkg::out_word_t                      result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [trcd_pkg::CIDX_W-1:0]         cfg_index,
    input  wire logic [trcd_pkg::RES_W-1:0]          cfg_data
);

    import trcd_pkg::*;

    rotation_t        rotation_reg, rotation_next;
    logic [RES_W-1:0] h_res_reg, h_res_next;
    logic [RES_W-1:0] v_res_reg, v_res_next;
    cfg_t             cfg_sat;

    logic      q_push, q_full, q_pop, q_empty;
    job_t      q_in, q_out;
    logic      out_push, out_full;
    out_word_t out_word;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rotation_next = rotation_reg;
        h_res_next    = h_res_reg;
        v_res_next    = v_res_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROTATION: rotation_next = rotation_t'(cfg_data[1:0]);
                REG_H_RES:    h_res_next    = cfg_data;
                REG_V_RES:    v_res_next    = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
            h_res_reg    <= RES_RESET;
            v_res_reg    <= RES_RESET;
        end
        else
        begin
            rotation_reg <= rotation_next;
            h_res_reg    <= h_res_next;
            v_res_reg    <= v_res_next;
        end
    end

    assign cfg_sat.rotation = rotation_reg;
    assign cfg_sat.h_res    = sat_res(h_res_reg);
    assign cfg_sat.v_res    = sat_res(v_res_reg);

    trcd_front #(
        .REPORT_LENGTH(REPORT_LENGTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .data   (data),
        .full   (full),
        .q_push (q_push),
        .q_word (q_in),
        .q_full (q_full)
    );

    trcd_fifo #(
        .word_t(job_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .word_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .word_out (q_out),
        .empty    (q_empty)
    );

    trcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_sat),
        .q_empty  (q_empty),
        .q_word   (q_out),
        .q_pop    (q_pop),
        .out_push (out_push),
        .out_word (out_word),
        .out_full (out_full)
    );

    trcd_fifo #(
        .word_t(out_word_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .word_in  (out_word),
        .full     (out_full),
        .pop      (pop),
        .word_out (result),
        .empty    (empty)
    );

    a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.outcome == OUT_BUS_ERROR || result.outcome == OUT_NO_POINTS))
        |-> !result.finger_present)
        else $error("finger flag set on bus error or empty report");

    a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.outcome == OUT_OK) |-> result.finger_present)
        else $error("finger flag clear on good touch");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.outcome == OUT_OK)
        |-> ({1'b0, result.x_coord} < cfg_sat.h_res && {1'b0, result.y_coord} < cfg_sat.v_res))
        else $error("coordinate outside display");

    a_zero_coord: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.outcome != OUT_OK)
        |-> (result.x_coord == '0 && result.y_coord == '0))
        else $error("coordinates not zero on failed report");

endmodule

`default_nettype wire
